// ----- design/dsky_relay_word_decoder_core_assert.svh -----
// Assertion macros used by the port-level checker.
`ifndef DSKY_RELAY_WORD_DECODER_CORE_ASSERT_SVH
`define DSKY_RELAY_WORD_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DSKY_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsky relay decoder assertion failed");

// Next-cycle implication, disabled during reset.
`define DSKY_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsky relay decoder assertion failed");

`endif

// ----- design/dsky_rwd_pkg.sv -----
// ----------------------------------------------------------------------------
// dsky_rwd_pkg
// Shared types, channel codes and the segment-code table of the DSKY decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dsky_rwd_pkg;

    localparam int CHAN_W  = 9;
    localparam int WORD_W  = 15;
    localparam int ROW_W   = 20;
    localparam int SIGN_W  = 6;
    localparam int MODE_W  = 24;
    localparam int LAMP_W  = 14;
    localparam int DIGIT_W = 4;
    localparam int SEL_W   = 4;

    localparam logic [CHAN_W-1:0] CH_RELAY   = 9'o010;
    localparam logic [CHAN_W-1:0] CH_LAMPS   = 9'o011;
    localparam logic [CHAN_W-1:0] CH_STBY    = 9'o013;
    localparam logic [CHAN_W-1:0] CH_RESTART = 9'o163;

    localparam logic [DIGIT_W-1:0] BLANK_DIGIT = 4'hF;

    // relay row selectors
    localparam logic [SEL_W-1:0] SEL_R3_D45  = 4'd1;
    localparam logic [SEL_W-1:0] SEL_R3_D23  = 4'd2;
    localparam logic [SEL_W-1:0] SEL_R23_D51 = 4'd3;
    localparam logic [SEL_W-1:0] SEL_R2_D34  = 4'd4;
    localparam logic [SEL_W-1:0] SEL_R2_D12  = 4'd5;
    localparam logic [SEL_W-1:0] SEL_R1_D45  = 4'd6;
    localparam logic [SEL_W-1:0] SEL_R1_D23  = 4'd7;
    localparam logic [SEL_W-1:0] SEL_R1_D1   = 4'd8;
    localparam logic [SEL_W-1:0] SEL_NOUN    = 4'd9;
    localparam logic [SEL_W-1:0] SEL_VERB    = 4'd10;
    localparam logic [SEL_W-1:0] SEL_PROG    = 4'd11;
    localparam logic [SEL_W-1:0] SEL_LAMPS   = 4'd12;

    typedef enum logic [2:0] {
        OP_IGNORE,
        OP_RELAY,
        OP_CH11,
        OP_CH13,
        OP_CH163
    } op_t;

    // request after classification, as held in the queue
    typedef struct packed {
        op_t                op;
        logic [SEL_W-1:0]   sel;
        logic               sgn;
        logic [DIGIT_W-1:0] left;
        logic [DIGIT_W-1:0] right;
        logic [WORD_W-1:0]  word;
    } cmd_t;

    // segment code to digit, 15 = blank
    function automatic logic [DIGIT_W-1:0] seg_to_digit(input logic [4:0] code);
        logic [DIGIT_W-1:0] d;
        begin
            unique case (code)
                5'd3:    d = 4'd1;
                5'd15:   d = 4'd4;
                5'd19:   d = 4'd7;
                5'd21:   d = 4'd0;
                5'd25:   d = 4'd2;
                5'd27:   d = 4'd3;
                5'd28:   d = 4'd6;
                5'd29:   d = 4'd8;
                5'd30:   d = 4'd5;
                5'd31:   d = 4'd9;
                default: d = BLANK_DIGIT;
            endcase
            return d;
        end
    endfunction

endpackage

`default_nettype wire

// ----- design/dsky_rwd_in_if.sv -----
// ----------------------------------------------------------------------------
// dsky_rwd_in_if
// Channel-write request channel: valid/ready with channel number and word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dsky_rwd_in_if;
    logic                              valid;
    logic                              ready;
    logic [dsky_rwd_pkg::CHAN_W-1:0]   channel;
    logic [dsky_rwd_pkg::WORD_W-1:0]   word;

    modport source (output valid, output channel, output word, input ready);
    modport sink   (input valid, input channel, input word, output ready);
endinterface

`default_nettype wire

// ----- design/dsky_rwd_out_if.sv -----
// ----------------------------------------------------------------------------
// dsky_rwd_out_if
// Result channel: valid/ready with update flag and packed display.
// ----------------------------------------------------------------------------
`default_nettype none

interface dsky_rwd_out_if;
    logic                            valid;
    logic                            ready;
    logic                            updated;
    logic [dsky_rwd_pkg::ROW_W-1:0]  row_one_digits;
    logic [dsky_rwd_pkg::ROW_W-1:0]  row_two_digits;
    logic [dsky_rwd_pkg::ROW_W-1:0]  row_three_digits;
    logic [dsky_rwd_pkg::SIGN_W-1:0] row_signs;
    logic [dsky_rwd_pkg::MODE_W-1:0] mode_digits;
    logic [dsky_rwd_pkg::LAMP_W-1:0] lamps;

    modport source (output valid, output updated, output row_one_digits,
                    output row_two_digits, output row_three_digits, output row_signs,
                    output mode_digits, output lamps, input ready);
    modport sink   (input valid, input updated, input row_one_digits,
                    input row_two_digits, input row_three_digits, input row_signs,
                    input mode_digits, input lamps, output ready);
endinterface

`default_nettype wire

// ----- design/dsky_relay_word_decoder_core.sv -----
// ----------------------------------------------------------------------------
// dsky_relay_word_decoder_core
// DSKY display keeper driven by guidance-computer output-channel writes.
// ----------------------------------------------------------------------------
// Each request on "in" is one channel write (channel, word); each produces
// exactly one result on "out" with an update flag and the whole packed display
// as it stands after that write. The block takes one request per clock while
// the queue has room: an accepted request is classified and queued, then
// applied to the display registers and the "out" register. Sustained rate
// is one request per cycle while the sink takes results; a two-entry queue
// between the classifier and the update stage holds requests while the result
// register is stalled, and in.ready drops only when that queue is full.
// Channel 010 carries a relay row (1..12) and two segment codes, decoded to
// digits (15 = blank); channels 011, 013 and 0163 set lamp, standby, blink
// and restart flags. Any other channel, or relay row 0 or 13..15, leaves the
// display alone and reports updated = 0. Reset blanks all digits and clears
// signs and lamps.
// ----------------------------------------------------------------------------
`default_nettype none

module dsky_relay_word_decoder_core (
    input  wire logic      clk,
    input  wire logic      rst_n,
    dsky_rwd_in_if.sink    in,
    dsky_rwd_out_if.source out
);
    import dsky_rwd_pkg::*;

    cmd_t front_cmd;    // classified request from the front
    cmd_t head_cmd;     // oldest queued request
    logic q_not_full;
    logic q_not_empty;
    logic q_pop;
    logic q_push;

    assign in.ready = q_not_full;
    assign q_push   = in.valid && q_not_full;

    // front: decode channel and segment codes
    dsky_rwd_front u_front (
        .channel (in.channel),
        .word    (in.word),
        .cmd     (front_cmd)
    );

    // queue: decouples acceptance from result back-pressure
    dsky_rwd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (front_cmd),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (head_cmd)
    );

    // back: display state and result register
    dsky_rwd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_not_empty),
        .cmd       (head_cmd),
        .cmd_pop   (q_pop),
        .out       (out)
    );

endmodule

`default_nettype wire

// ----- design/dsky_rwd_front.sv -----
// ----------------------------------------------------------------------------
// dsky_rwd_front
// Classifies a channel write and decodes both segment codes.
// ----------------------------------------------------------------------------
`default_nettype none

module dsky_rwd_front (
    input  wire logic [dsky_rwd_pkg::CHAN_W-1:0] channel,
    input  wire logic [dsky_rwd_pkg::WORD_W-1:0] word,
    output dsky_rwd_pkg::cmd_t                   cmd
);
    import dsky_rwd_pkg::*;

    logic [SEL_W-1:0] sel;
    logic             sel_ok;

    assign sel    = word[14:11];
    assign sel_ok = (sel != '0) && (sel <= SEL_LAMPS);

    always_comb
    begin
        cmd.sel   = sel;
        cmd.sgn   = word[10];
        cmd.left  = seg_to_digit(word[9:5]);
        cmd.right = seg_to_digit(word[4:0]);
        cmd.word  = word;
        unique case (channel)
            CH_RELAY:   cmd.op = sel_ok ? OP_RELAY : OP_IGNORE;
            CH_LAMPS:   cmd.op = OP_CH11;
            CH_STBY:    cmd.op = OP_CH13;
            CH_RESTART: cmd.op = OP_CH163;
            default:    cmd.op = OP_IGNORE;
        endcase
    end

endmodule

`default_nettype wire

// ----- design/dsky_rwd_queue.sv -----
// ----------------------------------------------------------------------------
// dsky_rwd_queue
// Two-entry request queue between the classifier and the display update.
// ----------------------------------------------------------------------------
`default_nettype none

module dsky_rwd_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire dsky_rwd_pkg::cmd_t push_cmd,
    output logic                    not_full,
    input  wire logic               pop,
    output logic                    not_empty,
    output dsky_rwd_pkg::cmd_t      head
);
    import dsky_rwd_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

// ----- design/dsky_rwd_back.sv -----
// ----------------------------------------------------------------------------
// dsky_rwd_back
// Applies a classified request to the display state and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module dsky_rwd_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    input  wire dsky_rwd_pkg::cmd_t cmd,
    output logic                    cmd_pop,
    dsky_rwd_out_if.source          out
);
    import dsky_rwd_pkg::*;

    logic [ROW_W-1:0]  row1_reg, row1_next;
    logic [ROW_W-1:0]  row2_reg, row2_next;
    logic [ROW_W-1:0]  row3_reg, row3_next;
    logic [SIGN_W-1:0] sign_reg, sign_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [LAMP_W-1:0] lamp_reg, lamp_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_upd_reg;
    logic [ROW_W-1:0]  out_row1_reg, out_row2_reg, out_row3_reg;
    logic [SIGN_W-1:0] out_sign_reg;
    logic [MODE_W-1:0] out_mode_reg;
    logic [LAMP_W-1:0] out_lamp_reg;
    logic              upd;

    // pop whenever the result register is free or being drained
    assign cmd_pop = cmd_valid && (!out_valid_reg || out.ready);
    assign upd     = (cmd.op != OP_IGNORE);

    // position p of a row sits at bits [19-4p -: 4]
    always_comb
    begin
        row1_next = row1_reg;
        row2_next = row2_reg;
        row3_next = row3_reg;
        sign_next = sign_reg;
        mode_next = mode_reg;
        lamp_next = lamp_reg;
        unique case (cmd.op)
            OP_RELAY:
            begin
                unique case (cmd.sel)
                    SEL_R3_D45:
                    begin
                        row3_next[3:0] = cmd.right;
                        row3_next[7:4] = cmd.left;
                        sign_next[5]   = cmd.sgn;
                    end
                    SEL_R3_D23:
                    begin
                        row3_next[11:8]  = cmd.right;
                        row3_next[15:12] = cmd.left;
                        sign_next[4]     = cmd.sgn;
                    end
                    SEL_R23_D51:
                    begin
                        row3_next[19:16] = cmd.right;
                        row2_next[3:0]   = cmd.left;
                    end
                    SEL_R2_D34:
                    begin
                        row2_next[7:4]  = cmd.right;
                        row2_next[11:8] = cmd.left;
                        sign_next[3]    = cmd.sgn;
                    end
                    SEL_R2_D12:
                    begin
                        row2_next[15:12] = cmd.right;
                        row2_next[19:16] = cmd.left;
                        sign_next[2]     = cmd.sgn;
                    end
                    SEL_R1_D45:
                    begin
                        row1_next[3:0] = cmd.right;
                        row1_next[7:4] = cmd.left;
                        sign_next[1]   = cmd.sgn;
                    end
                    SEL_R1_D23:
                    begin
                        row1_next[11:8]  = cmd.right;
                        row1_next[15:12] = cmd.left;
                        sign_next[0]     = cmd.sgn;
                    end
                    SEL_R1_D1:
                        row1_next[19:16] = cmd.right;
                    SEL_NOUN:
                        mode_next[7:0] = {cmd.left, cmd.right};
                    SEL_VERB:
                        mode_next[15:8] = {cmd.left, cmd.right};
                    SEL_PROG:
                        mode_next[23:16] = {cmd.left, cmd.right};
                    SEL_LAMPS:
                        lamp_next[11:6] = {cmd.word[8], cmd.word[7], cmd.word[5],
                                           cmd.word[4], cmd.word[3], cmd.word[2]};
                    default:
                        row1_next = row1_reg;
                endcase
            end
            OP_CH11:
                lamp_next[4:0] = {cmd.word[6], cmd.word[4], cmd.word[3],
                                  cmd.word[2], cmd.word[1]};
            OP_CH13:
                lamp_next[5] = cmd.word[9];
            OP_CH163:
            begin
                lamp_next[12] = cmd.word[5];
                lamp_next[13] = cmd.word[7];
            end
            default:
                lamp_next = lamp_reg;
        endcase
    end

    always_comb
    begin
        if (cmd_pop)
            out_valid_next = 1'b1;
        else if (out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row1_reg      <= {(ROW_W/DIGIT_W){BLANK_DIGIT}};
            row2_reg      <= {(ROW_W/DIGIT_W){BLANK_DIGIT}};
            row3_reg      <= {(ROW_W/DIGIT_W){BLANK_DIGIT}};
            mode_reg      <= {(MODE_W/DIGIT_W){BLANK_DIGIT}};
            sign_reg      <= '0;
            lamp_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd_pop)
            begin
                row1_reg <= row1_next;
                row2_reg <= row2_next;
                row3_reg <= row3_next;
                sign_reg <= sign_next;
                mode_reg <= mode_next;
                lamp_reg <= lamp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            out_upd_reg  <= upd;
            out_row1_reg <= row1_next;
            out_row2_reg <= row2_next;
            out_row3_reg <= row3_next;
            out_sign_reg <= sign_next;
            out_mode_reg <= mode_next;
            out_lamp_reg <= lamp_next;
        end
    end

    assign out.valid            = out_valid_reg;
    assign out.updated          = out_upd_reg;
    assign out.row_one_digits   = out_row1_reg;
    assign out.row_two_digits   = out_row2_reg;
    assign out.row_three_digits = out_row3_reg;
    assign out.row_signs        = out_sign_reg;
    assign out.mode_digits      = out_mode_reg;
    assign out.lamps            = out_lamp_reg;

endmodule

`default_nettype wire

// ----- design/dsky_rwd_checker.sv -----
// ----------------------------------------------------------------------------
// dsky_rwd_checker
// Port-level checks of the DSKY decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dsky_relay_word_decoder_core_assert.svh"

module dsky_rwd_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic                              out_updated,
    input wire logic [dsky_rwd_pkg::ROW_W-1:0]    out_row_one,
    input wire logic [dsky_rwd_pkg::ROW_W-1:0]    out_row_two,
    input wire logic [dsky_rwd_pkg::ROW_W-1:0]    out_row_three,
    input wire logic [dsky_rwd_pkg::SIGN_W-1:0]   out_signs,
    input wire logic [dsky_rwd_pkg::MODE_W-1:0]   out_mode,
    input wire logic [dsky_rwd_pkg::LAMP_W-1:0]   out_lamps
);
    import dsky_rwd_pkg::*;

    logic out_stall;
    logic digits_ok;

    assign out_stall = out_valid && !out_ready;

    // every shown digit is 0..9 or blank
    always_comb
    begin
        digits_ok = 1'b1;
        for (int i = 0; i < ROW_W / DIGIT_W; i++)
        begin
            if (out_row_one[i*DIGIT_W +: DIGIT_W] > 4'd9 &&
                out_row_one[i*DIGIT_W +: DIGIT_W] != BLANK_DIGIT)
                digits_ok = 1'b0;
            if (out_row_two[i*DIGIT_W +: DIGIT_W] > 4'd9 &&
                out_row_two[i*DIGIT_W +: DIGIT_W] != BLANK_DIGIT)
                digits_ok = 1'b0;
            if (out_row_three[i*DIGIT_W +: DIGIT_W] > 4'd9 &&
                out_row_three[i*DIGIT_W +: DIGIT_W] != BLANK_DIGIT)
                digits_ok = 1'b0;
        end
        for (int i = 0; i < MODE_W / DIGIT_W; i++)
        begin
            if (out_mode[i*DIGIT_W +: DIGIT_W] > 4'd9 &&
                out_mode[i*DIGIT_W +: DIGIT_W] != BLANK_DIGIT)
                digits_ok = 1'b0;
        end
    end

    // a waiting request is held off only after a stalled result
    `DSKY_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid)
    `DSKY_ASSERT_NEXT(a_out_stable, clk, rst_n, out_stall, $stable(out_updated) && $stable(out_row_one) && $stable(out_row_two) && $stable(out_row_three) && $stable(out_signs) && $stable(out_mode) && $stable(out_lamps))
    `DSKY_ASSERT_NOW(a_digits_legal, clk, rst_n, out_valid, digits_ok)
    `DSKY_ASSERT_NOW(a_ready_only_on_stall, clk, rst_n, in_valid && !in_ready, $past(out_stall))

endmodule

bind dsky_relay_word_decoder_core dsky_rwd_checker u_dsky_rwd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in.valid),
    .in_ready      (in.ready),
    .out_valid     (out.valid),
    .out_ready     (out.ready),
    .out_updated   (out.updated),
    .out_row_one   (out.row_one_digits),
    .out_row_two   (out.row_two_digits),
    .out_row_three (out.row_three_digits),
    .out_signs     (out.row_signs),
    .out_mode      (out.mode_digits),
    .out_lamps     (out.lamps)
);

`default_nettype wire

// ----- sim/dsky_relay_word_decoder_core_checker.sv -----
// ----------------------------------------------------------------------------
// dsky_relay_word_decoder_core_checker
// Watches the request and result channels of the DSKY relay word decoder,
// keeps its own copy of the display state, predicts the packed display for
// every accepted request and compares each accepted result, field by field,
// against the oldest prediction still waiting.
// ----------------------------------------------------------------------------

module dsky_relay_word_decoder_core_checker (
    input  logic    clk,
    input  logic    rst_n,
    dsky_rwd_in_if  req_mon,
    dsky_rwd_out_if res_mon,
    output int      mismatch_count,
    output int      results_outstanding
);

    import dsky_rwd_pkg::*;

    typedef struct packed {
        logic              updated;
        logic [ROW_W-1:0]  row_one;
        logic [ROW_W-1:0]  row_two;
        logic [ROW_W-1:0]  row_three;
        logic [SIGN_W-1:0] signs;
        logic [MODE_W-1:0] mode;
        logic [LAMP_W-1:0] lamps;
    } display_t;

    // segment code -> digit, one nibble per code, code 0 in the low nibble
    localparam logic [127:0] SEG_TABLE = 128'h9586_3F2F_FF0F_7FFF_4FFF_FFFF_FFFF_1FFF;

    logic [DIGIT_W-1:0] row_digit [15];   // row*5 + position
    logic [SIGN_W-1:0]  sign_state;
    logic [DIGIT_W-1:0] mode_digit [6];   // prog1 prog2 verb1 verb2 noun1 noun2
    logic [LAMP_W-1:0]  lamp_state;

    display_t expected_display_q [$];

    function automatic display_t apply_write(input logic [CHAN_W-1:0] ch,
                                             input logic [WORD_W-1:0] w);
        display_t           res;
        logic [SEL_W-1:0]   sel;
        logic               sgn;
        logic [DIGIT_W-1:0] left;
        logic [DIGIT_W-1:0] right;
        sel   = w[14:11];
        sgn   = w[10];
        left  = SEG_TABLE[{w[9:5], 2'b00} +: 4];
        right = SEG_TABLE[{w[4:0], 2'b00} +: 4];
        res.updated = 1'b1;
        case (ch)
            CH_RELAY:
                case (sel)
                    SEL_R3_D45:  begin row_digit[14] = right; row_digit[13] = left;
                                       sign_state[5] = sgn; end
                    SEL_R3_D23:  begin row_digit[12] = right; row_digit[11] = left;
                                       sign_state[4] = sgn; end
                    SEL_R23_D51: begin row_digit[10] = right; row_digit[9] = left; end
                    SEL_R2_D34:  begin row_digit[8] = right; row_digit[7] = left;
                                       sign_state[3] = sgn; end
                    SEL_R2_D12:  begin row_digit[6] = right; row_digit[5] = left;
                                       sign_state[2] = sgn; end
                    SEL_R1_D45:  begin row_digit[4] = right; row_digit[3] = left;
                                       sign_state[1] = sgn; end
                    SEL_R1_D23:  begin row_digit[2] = right; row_digit[1] = left;
                                       sign_state[0] = sgn; end
                    SEL_R1_D1:   row_digit[0] = right;
                    SEL_NOUN:    begin mode_digit[4] = left; mode_digit[5] = right; end
                    SEL_VERB:    begin mode_digit[2] = left; mode_digit[3] = right; end
                    SEL_PROG:    begin mode_digit[0] = left; mode_digit[1] = right; end
                    SEL_LAMPS:
                    begin
                        lamp_state[6]  = w[2];
                        lamp_state[7]  = w[3];
                        lamp_state[8]  = w[4];
                        lamp_state[9]  = w[5];
                        lamp_state[10] = w[7];
                        lamp_state[11] = w[8];
                    end
                    default:     res.updated = 1'b0;
                endcase
            CH_LAMPS:
            begin
                lamp_state[0] = w[1];
                lamp_state[1] = w[2];
                lamp_state[2] = w[3];
                lamp_state[3] = w[4];
                lamp_state[4] = w[6];
            end
            CH_STBY:
                lamp_state[5] = w[9];
            CH_RESTART:
            begin
                lamp_state[12] = w[5];
                lamp_state[13] = w[7];
            end
            default:
                res.updated = 1'b0;
        endcase
        res.row_one   = {row_digit[0], row_digit[1], row_digit[2], row_digit[3],
                         row_digit[4]};
        res.row_two   = {row_digit[5], row_digit[6], row_digit[7], row_digit[8],
                         row_digit[9]};
        res.row_three = {row_digit[10], row_digit[11], row_digit[12], row_digit[13],
                         row_digit[14]};
        res.signs     = sign_state;
        res.mode      = {mode_digit[0], mode_digit[1], mode_digit[2], mode_digit[3],
                         mode_digit[4], mode_digit[5]};
        res.lamps     = lamp_state;
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [MODE_W-1:0] want,
                                 input logic [MODE_W-1:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        display_t want;
        display_t got;
        if (!rst_n)
        begin
            foreach (row_digit[i])  row_digit[i]  = BLANK_DIGIT;
            foreach (mode_digit[i]) mode_digit[i] = BLANK_DIGIT;
            sign_state = '0;
            lamp_state = '0;
            expected_display_q.delete();
            results_outstanding = 0;
            mismatch_count = 0;
        end
        else
        begin
            if (req_mon.valid && req_mon.ready)
                expected_display_q.push_back(apply_write(req_mon.channel, req_mon.word));
            if (res_mon.valid && res_mon.ready)
            begin
                got = '{res_mon.updated, res_mon.row_one_digits, res_mon.row_two_digits,
                        res_mon.row_three_digits, res_mon.row_signs, res_mon.mode_digits,
                        res_mon.lamps};
                if (expected_display_q.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result with nothing expected, expected none, actual %h",
                             $time, got);
                end
                else
                begin
                    want = expected_display_q.pop_front();
                    compare_field("updated", MODE_W'(want.updated), MODE_W'(got.updated));
                    compare_field("row_one_digits", MODE_W'(want.row_one),
                                  MODE_W'(got.row_one));
                    compare_field("row_two_digits", MODE_W'(want.row_two),
                                  MODE_W'(got.row_two));
                    compare_field("row_three_digits", MODE_W'(want.row_three),
                                  MODE_W'(got.row_three));
                    compare_field("row_signs", MODE_W'(want.signs), MODE_W'(got.signs));
                    compare_field("mode_digits", want.mode, got.mode);
                    compare_field("lamps", MODE_W'(want.lamps), MODE_W'(got.lamps));
                end
            end
            results_outstanding = expected_display_q.size();
        end
    end

endmodule

// ----- sim/dsky_relay_word_decoder_core_tb.sv -----
// ----------------------------------------------------------------------------
// dsky_relay_word_decoder_core_tb
// Drives channel writes into the DSKY relay word decoder: a directed opening
// over all four display channels, every relay row, bad rows, blank codes and field
// extremes, then random writes in three traffic phases. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------

module dsky_relay_word_decoder_core_tb;

    import dsky_rwd_pkg::*;

    // random writes that touch the display; ignored writes come on top
    localparam int RANDOM_WRITES   = 330;
    localparam int SETTLE_CYCLES   = 10;
    localparam int TIMEOUT_UNITS   = 2_000_000;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   mismatch_count;
    int   results_outstanding;

    dsky_rwd_in_if  in_ch ();
    dsky_rwd_out_if out_ch ();

    dsky_relay_word_decoder_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch),
        .out   (out_ch)
    );

    dsky_relay_word_decoder_core_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .req_mon             (in_ch),
        .res_mon             (out_ch),
        .mismatch_count      (mismatch_count),
        .results_outstanding (results_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: ready is redrawn every cycle from the current stall rate.
    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    // Pack a relay word: row selector, sign, left and right segment codes.
    function automatic logic [WORD_W-1:0] relay_word(input logic [SEL_W-1:0] sel,
                                                     input logic sgn,
                                                     input logic [4:0] left_code,
                                                     input logic [4:0] right_code);
        return {sel, sgn, left_code, right_code};
    endfunction

    // Mostly real digit codes; now and then any code, which hits the
    // unused codes that decode to blank.
    function automatic logic [4:0] pick_code();
        if ($urandom_range(3) == 0)
            return 5'($urandom_range(31));
        case ($urandom_range(9))
            0:       return 5'd3;
            1:       return 5'd15;
            2:       return 5'd19;
            3:       return 5'd21;
            4:       return 5'd25;
            5:       return 5'd27;
            6:       return 5'd28;
            7:       return 5'd29;
            8:       return 5'd30;
            default: return 5'd31;
        endcase
    endfunction

    // One request. Idle cycles are drawn before it; returns in the time step
    // of the accepting edge so the next call drives in that same step and
    // stale data never stays on the bus after it is taken.
    task automatic send_request(input logic [CHAN_W-1:0] ch, input logic [WORD_W-1:0] w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.channel <= ch;
        in_ch.word    <= w;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // Hold the sender off until every predicted result has come back.
    // The first edge lets the checker book the last accepted request.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (results_outstanding == 0);
    endtask

    initial
    begin : stimulus
        int          phase;
        int          counted;
        int          pick;
        logic [CHAN_W-1:0] ch;
        logic [WORD_W-1:0] w;

        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.channel <= '0;
        in_ch.word    <= '0;
        send_idle_pct = 22;
        recv_idle_pct = 67;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed opening ----
        // ignored channels at both ends of the range: show the reset display
        send_request('0, '0);
        send_request('1, '1);
        // bad relay rows: zero, thirteen and fifteen
        send_request(CH_RELAY, relay_word(4'd0, 1'b1, 5'd31, 5'd31));
        send_request(CH_RELAY, relay_word(4'd13, 1'b1, 5'd21, 5'd3));
        send_request(CH_RELAY, relay_word(4'd15, 1'b1, 5'd29, 5'd30));
        // every digit relay row, sign set except on noun, verb and program, a spread of real digit codes
        send_request(CH_RELAY, relay_word(SEL_R3_D45, 1'b1, 5'd21, 5'd3));
        send_request(CH_RELAY, relay_word(SEL_R3_D23, 1'b1, 5'd25, 5'd27));
        send_request(CH_RELAY, relay_word(SEL_R23_D51, 1'b1, 5'd15, 5'd30));
        send_request(CH_RELAY, relay_word(SEL_R2_D34, 1'b1, 5'd28, 5'd19));
        send_request(CH_RELAY, relay_word(SEL_R2_D12, 1'b1, 5'd29, 5'd31));
        send_request(CH_RELAY, relay_word(SEL_R1_D45, 1'b1, 5'd3, 5'd21));
        send_request(CH_RELAY, relay_word(SEL_R1_D23, 1'b1, 5'd27, 5'd25));
        send_request(CH_RELAY, relay_word(SEL_R1_D1, 1'b1, 5'd30, 5'd15));
        send_request(CH_RELAY, relay_word(SEL_NOUN, 1'b0, 5'd19, 5'd28));
        send_request(CH_RELAY, relay_word(SEL_VERB, 1'b0, 5'd31, 5'd29));
        send_request(CH_RELAY, relay_word(SEL_PROG, 1'b0, 5'd21, 5'd21));
        // lamp row all on, then all off
        send_request(CH_RELAY, relay_word(SEL_LAMPS, 1'b1, 5'd31, 5'd31));
        send_request(CH_RELAY, relay_word(SEL_LAMPS, 1'b0, 5'd0, 5'd0));
        // unused segment codes blank the digits; sign cleared
        send_request(CH_RELAY, relay_word(SEL_R3_D45, 1'b0, 5'd0, 5'd1));
        // lamp channels at full and empty words, standby with its flag bit only
        send_request(CH_LAMPS, '1);
        send_request(CH_LAMPS, '0);
        send_request(CH_STBY, 15'h0200);
        send_request(CH_RESTART, '1);
        send_request(CH_RESTART, '0);

        // ---- random phases ----
        // sender 22 / receiver 67, then swapped, then both flat out
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 67 : 0;
            recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 22 : 0;
            counted = 0;
            while (counted < RANDOM_WRITES / 3 + (phase == 0 ? RANDOM_WRITES % 3 : 0))
            begin
                pick = $urandom_range(99);
                w    = 15'($urandom_range(32767));
                if (pick < 60)
                begin
                    // well-formed relay write with random row, sign and codes
                    ch = CH_RELAY;
                    w  = relay_word(4'($urandom_range(1, 12)), w[10], pick_code(),
                                    pick_code());
                    counted++;
                end
                else if (pick < 74)
                begin
                    ch = CH_LAMPS;
                    counted++;
                end
                else if (pick < 81)
                begin
                    ch = CH_STBY;
                    counted++;
                end
                else if (pick < 88)
                begin
                    ch = CH_RESTART;
                    counted++;
                end
                else if (pick < 94)
                begin
                    // relay write with a row the display ignores
                    ch = CH_RELAY;
                    w[14:11] = ($urandom_range(3) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
                end
                else
                begin
                    // any channel at all; the lamp, standby and restart ones still count
                    ch = 9'($urandom_range(511));
                    if (ch == CH_LAMPS || ch == CH_STBY || ch == CH_RESTART)
                        counted++;
                end
                send_request(ch, w);
            end
            // the sender sits idle until every outstanding result has drained
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Hard stop if a handshake never completes.
    initial
    begin
        #(TIMEOUT_UNITS);
        $display("Regression FAIL");
        $finish;
    end

endmodule
